// ----- rtl/env_brdf_split_sum_lut_texel_unit_defines.svh -----
// Assertion macros shared by the BRDF lookup texel unit.
`ifndef ENV_BRDF_SPLIT_SUM_LUT_TEXEL_UNIT_DEFINES_SVH
`define ENV_BRDF_SPLIT_SUM_LUT_TEXEL_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define EBL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and disabled during reset.
`define EBL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ebl_pkg.sv -----
// Types, constants and helper functions of the BRDF lookup texel unit.
`timescale 1ns / 1ps
package ebl_pkg;

    localparam int IDX_W = 10;
    localparam int RES_W = 11;
    localparam int Q_W = 17;
    localparam int TEX_W = 20;
    localparam int OUT_W = 16;

    localparam int MAX_RESOLUTION = 1024;
    localparam logic [RES_W-1:0] RES_RESET = RES_W'(64);

    localparam int DIV_STAGES = Q_W;
    localparam int SHADE_STAGES = 6;

    localparam int CFG_ADDR_W = 3;
    localparam logic REG_TABLE_RESOLUTION = 1'b0;

    // Coefficients of the polynomial approximation in Q1.16; K_EXP is Q4.16.
    localparam int K_C0Y = 1802;
    localparam int K_C1Y = 2785;
    localparam int K_C0Z = 37487;
    localparam int K_C1Z = 68157;
    localparam int K_C0W = 1442;
    localparam int K_C1W = 2621;
    localparam int K_AB = 68157;
    localparam int K_EXP = 608174;

    typedef struct packed {
        logic [IDX_W-1:0] column_index;
        logic [IDX_W-1:0] row_index;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] scale_term;
        logic signed [OUT_W-1:0] bias_term;
        logic [TEX_W-1:0]        texel_index;
        logic                    status;
    } out_item_t;

    // 2^(-k/16) in Q1.16 for k = 0 .. 16.
    function automatic logic [16:0] exp2_neg_entry(input logic [4:0] k);
        logic [16:0] r;
        unique case (k)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd62757;
            5'd2:    r = 17'd60097;
            5'd3:    r = 17'd57549;
            5'd4:    r = 17'd55109;
            5'd5:    r = 17'd52773;
            5'd6:    r = 17'd50535;
            5'd7:    r = 17'd48393;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd44376;
            5'd10:   r = 17'd42495;
            5'd11:   r = 17'd40693;
            5'd12:   r = 17'd38968;
            5'd13:   r = 17'd37316;
            5'd14:   r = 17'd35734;
            5'd15:   r = 17'd34219;
            5'd16:   r = 17'd32768;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // Q1.16 to Q2.14 with rounding half up and saturation.
    function automatic logic signed [OUT_W-1:0] sat_q14(input logic signed [39:0] v);
        logic signed [39:0] r;
        r = (v + 40'sd2) >>> 2;
        if (r > 40'sd32767)
        begin
            r = 40'sd32767;
        end
        else if (r < -40'sd32768)
        begin
            r = -40'sd32768;
        end
        return OUT_W'(r);
    endfunction

endpackage

// ----- rtl/ebl_divider.sv -----
// Pipelined restoring divider: one quotient bit per stage, for round(idx*65536/den).
`timescale 1ns / 1ps
module ebl_divider
    import ebl_pkg::*;
(
    input  logic             clk,
    input  logic             adv,
    input  logic [IDX_W-1:0] idx,
    input  logic [RES_W-1:0] den,
    output logic [Q_W-1:0]   quot
);

    localparam int NUM_W = IDX_W + Q_W;

    logic [NUM_W-1:0] num;
    logic [RES_W-1:0] rem_reg  [DIV_STAGES];
    logic [RES_W-1:0] rem_next [DIV_STAGES];
    logic [Q_W-1:0]   low_reg  [DIV_STAGES];
    logic [Q_W-1:0]   low_next [DIV_STAGES];
    logic [Q_W-1:0]   quo_reg  [DIV_STAGES];
    logic [Q_W-1:0]   quo_next [DIV_STAGES];

    // Rounded numerator; its top bits already lie below the divisor.
    assign num = {idx, 16'd0} + NUM_W'(den >> 1);

    // Each stage shifts in one numerator bit and tries one subtraction.
    always_comb
    begin
        logic [RES_W-1:0] r_in;
        logic [Q_W-1:0]   l_in;
        logic [Q_W-1:0]   q_in;
        logic [RES_W:0]   r2;
        logic             ge;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                r_in = RES_W'(num[NUM_W-1:Q_W]);
                l_in = num[Q_W-1:0];
                q_in = '0;
            end
            else
            begin
                r_in = rem_reg[s-1];
                l_in = low_reg[s-1];
                q_in = quo_reg[s-1];
            end
            r2 = {r_in, l_in[Q_W-1]};
            ge = (r2 >= {1'b0, den});
            rem_next[s] = ge ? RES_W'(r2 - {1'b0, den}) : RES_W'(r2);
            low_next[s] = {l_in[Q_W-2:0], 1'b0};
            quo_next[s] = {q_in[Q_W-2:0], ge};
        end
    end

    // Stage registers advance together with the rest of the pipeline.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                rem_reg[s] <= rem_next[s];
                low_reg[s] <= low_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quot = quo_reg[DIV_STAGES-1];

endmodule

// ----- rtl/ebl_shade.sv -----
// Six-stage fixed-point evaluation of the scale and bias terms from ndotv and roughness.
`timescale 1ns / 1ps
module ebl_shade
    import ebl_pkg::*;
(
    input  logic                    clk,
    input  logic                    adv,
    input  logic [Q_W-1:0]          x,
    input  logic [Q_W-1:0]          y,
    output logic signed [OUT_W-1:0] scale,
    output logic signed [OUT_W-1:0] bias
);

    // Stage 1 registers: raw products.
    logic [Q_W-1:0]  rx1_reg;
    logic [27:0]     py0_reg;
    logic [31:0]     py1_reg;
    logic [27:0]     py2_reg;
    logic [35:0]     pt_reg;
    logic [33:0]     prx2_reg;
    // Stage 2 registers: rounded terms and exp2 interpolation product.
    logic [Q_W-1:0]     rx2s_reg;
    logic signed [17:0] ry2_reg;
    logic [Q_W-1:0]     rz2_reg;
    logic signed [17:0] rw2_reg;
    logic [Q_W-1:0]     rxx2_reg;
    logic [3:0]         n2_reg;
    logic [16:0]        base2_reg;
    logic [23:0]        prod2_reg;
    // Stage 3 registers.
    logic [Q_W-1:0]     m3_reg;
    logic [Q_W-1:0]     rx3_reg;
    logic signed [17:0] ry3_reg;
    logic [Q_W-1:0]     rz3_reg;
    logic signed [17:0] rw3_reg;
    // Stage 4 registers.
    logic [33:0]        pm4_reg;
    logic signed [17:0] ry4_reg;
    logic [Q_W-1:0]     rz4_reg;
    logic signed [17:0] rw4_reg;
    // Stage 5 registers.
    logic signed [39:0] pa5_reg;
    logic [Q_W-1:0]     rz5_reg;
    logic signed [17:0] rw5_reg;
    // Stage 6 registers.
    logic signed [OUT_W-1:0] scale_reg;
    logic signed [OUT_W-1:0] bias_reg;

    logic [Q_W-1:0]     rx_c;
    logic [19:0]        t_c;
    logic [3:0]         k_c;
    logic [11:0]        diff_c;
    logic [16:0]        v_c;
    logic [17:0]        half_c;
    logic [Q_W-1:0]     e_c;
    logic signed [18:0] a004_c;
    logic signed [39:0] a_c;
    logic signed [39:0] b_c;

    // Stage 1: one minus roughness and the products that feed every term.
    assign rx_c = Q_W'(18'd65536 - {1'b0, y});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx1_reg  <= rx_c;
            py0_reg  <= 28'(y) * 28'(K_C0Y);
            py1_reg  <= 32'(y) * 32'(K_C0Z);
            py2_reg  <= 28'(y) * 28'(K_C0W);
            pt_reg   <= 36'(x) * 36'(K_EXP);
            prx2_reg <= 34'(rx_c) * 34'(rx_c);
        end
    end

    // Stage 2: rounding, exp2 table lookup and the interpolation product.
    assign t_c = 20'((pt_reg + 36'd32768) >> 16);
    assign k_c = t_c[15:12];
    assign diff_c = 12'(exp2_neg_entry({1'b0, k_c}) - exp2_neg_entry(5'({1'b0, k_c}) + 5'd1));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx2s_reg  <= rx1_reg;
            ry2_reg   <= 18'(K_C1Y) - 18'((py0_reg + 28'd32768) >> 16);
            rz2_reg   <= Q_W'(K_C1Z) - Q_W'((py1_reg + 32'd32768) >> 16);
            rw2_reg   <= 18'((py2_reg + 28'd32768) >> 16) - 18'(K_C1W);
            rxx2_reg  <= Q_W'((prx2_reg + 34'd32768) >> 16);
            n2_reg    <= t_c[19:16];
            base2_reg <= exp2_neg_entry({1'b0, k_c});
            prod2_reg <= 24'(diff_c) * 24'(t_c[11:0]);
        end
    end

    // Stage 3: finish exp2 with a rounding shift, then take the minimum.
    assign v_c = base2_reg - 17'((prod2_reg + 24'd2048) >> 12);
    assign half_c = (n2_reg == 4'd0) ? 18'd0 : (18'd1 << (n2_reg - 4'd1));
    assign e_c = (n2_reg == 4'd0) ? v_c : Q_W'(({1'b0, v_c} + half_c) >> n2_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_reg  <= (rxx2_reg < e_c) ? rxx2_reg : e_c;
            rx3_reg <= rx2s_reg;
            ry3_reg <= ry2_reg;
            rz3_reg <= rz2_reg;
            rw3_reg <= rw2_reg;
        end
    end

    // Stage 4: scale the minimum by one minus roughness.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pm4_reg <= 34'(m3_reg) * 34'(rx3_reg);
            ry4_reg <= ry3_reg;
            rz4_reg <= rz3_reg;
            rw4_reg <= rw3_reg;
        end
    end

    // Stage 5: shared term a004 and its product with 1.04.
    assign a004_c = $signed({2'b00, Q_W'((pm4_reg + 34'd32768) >> 16)}) + 19'(ry4_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa5_reg <= 40'(a004_c) * 40'(K_AB);
            rz5_reg <= rz4_reg;
            rw5_reg <= rw4_reg;
        end
    end

    // Stage 6: both terms, converted to Q2.14 with saturation.
    assign a_c = ((40'sd32768 - pa5_reg) >>> 16) + $signed({23'd0, rz5_reg});
    assign b_c = ((pa5_reg + 40'sd32768) >>> 16) + 40'(rw5_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scale_reg <= sat_q14(a_c);
            bias_reg  <= sat_q14(b_c);
        end
    end

    assign scale = scale_reg;
    assign bias  = bias_reg;

endmodule

// ----- rtl/env_brdf_split_sum_lut_texel_unit.sv -----
// Top level of the BRDF lookup texel unit: register port, front stage and pipeline control.
`timescale 1ns / 1ps
`include "env_brdf_split_sum_lut_texel_unit_defines.svh"
// One texel of the split-sum environment BRDF table per transfer: the unit
// accepts a column and row index every cycle while in_stall is low and
// returns the scale and bias terms in signed Q2.14 with the texel's linear
// index. Results pass the front stage, the 17-stage pipelined divider that
// turns the indices into ndotv and roughness (one quotient bit per stage),
// and six arithmetic stages. A stall on the output holds the whole pipeline
// in place; the input stalls only while a finished result waits. Write
// table_resolution at address 0 only while no transfer is in flight.
module env_brdf_split_sum_lut_texel_unit
    import ebl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    localparam int LAT = 1 + DIV_STAGES + SHADE_STAGES;

    typedef struct packed {
        logic             oor;
        logic             one_res;
        logic [TEX_W-1:0] texel;
    } side_t;

    logic [RES_W-1:0]   res_reg;
    logic [RES_W-1:0]   res_c;
    logic               reg_sel;
    logic               adv;
    logic [LAT-1:0]     valid_reg;
    side_t              side_reg [LAT];
    side_t              side_next;
    logic [IDX_W-1:0]   col_reg;
    logic [IDX_W-1:0]   row_reg;
    logic [Q_W-1:0]     quot_x;
    logic [Q_W-1:0]     quot_y;
    logic [Q_W-1:0]     x_c;
    logic [Q_W-1:0]     y_c;
    logic signed [OUT_W-1:0] scale_w;
    logic signed [OUT_W-1:0] bias_w;

    // Register port: one register, written on the access phase.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_TABLE_RESOLUTION);
    assign prdata  = reg_sel ? 32'(res_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= RES_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            res_reg <= pwdata[RES_W-1:0];
        end
    end

    // Effective resolution, clamped to the largest supported table.
    assign res_c = (32'(res_reg) > 32'(MAX_RESOLUTION)) ? RES_W'(MAX_RESOLUTION) : res_reg;

    // The pipeline moves unless a finished result is held by the receiver.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // Front stage: range check, single-texel case and linear index.
    always_comb
    begin
        side_next.oor = ({1'b0, in_data.column_index} >= res_c)
                     || ({1'b0, in_data.row_index} >= res_c);
        side_next.one_res = (res_c <= RES_W'(1));
        side_next.texel = TEX_W'(21'(in_data.row_index) * 21'(res_c)
                               + 21'(in_data.column_index));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    // Side information travels alongside the arithmetic.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_reg     <= in_data.column_index;
            row_reg     <= in_data.row_index;
            side_reg[0] <= side_next;
            for (int s = 1; s < LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    ebl_divider u_div_x (
        .clk  (clk),
        .adv  (adv),
        .idx  (col_reg),
        .den  (RES_W'(res_c - RES_W'(1))),
        .quot (quot_x)
    );

    ebl_divider u_div_y (
        .clk  (clk),
        .adv  (adv),
        .idx  (row_reg),
        .den  (RES_W'(res_c - RES_W'(1))),
        .quot (quot_y)
    );

    // A one-texel table has ndotv and roughness both zero.
    assign x_c = side_reg[DIV_STAGES].one_res ? '0 : quot_x;
    assign y_c = side_reg[DIV_STAGES].one_res ? '0 : quot_y;

    ebl_shade u_shade (
        .clk   (clk),
        .adv   (adv),
        .x     (x_c),
        .y     (y_c),
        .scale (scale_w),
        .bias  (bias_w)
    );

    // Result transfer; an out-of-range texel sets status and reports zero terms and index.
    assign out_valid = valid_reg[LAT-1];

    always_comb
    begin
        out_data.status      = side_reg[LAT-1].oor;
        out_data.scale_term  = side_reg[LAT-1].oor ? '0 : scale_w;
        out_data.bias_term   = side_reg[LAT-1].oor ? '0 : bias_w;
        out_data.texel_index = side_reg[LAT-1].oor ? '0 : side_reg[LAT-1].texel;
    end

    `EBL_ASSERT_IMP(a_oor_zero, out_valid && out_data.status,
        out_data.scale_term == 16'sd0 && out_data.bias_term == 16'sd0
            && out_data.texel_index == 20'd0,
        "out-of-range result carries nonzero fields")
    `EBL_ASSERT_IMP(a_stall_needs_result, in_stall, out_valid && out_stall,
        "input stalled without a held result")
    `EBL_ASSERT_NXT(a_pipe_frozen, !adv, $stable(valid_reg),
        "valid bits moved while the pipeline was held")

endmodule
